// File: hdl/sira_pkg.sv
// Package for the signed integer to radix ASCII unit: widths, payload types, FSM and control.
`timescale 1ns / 1ps

package sira_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int RADIX_BITS   = 6;
    localparam int DIGIT_BITS   = 6;
    localparam int CHAR_BITS    = 7;
    localparam int IDX_BITS     = $clog2(VALUE_BITS);
    localparam int CNT_BITS     = $clog2(VALUE_BITS + 1);
    localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
    localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT = DIGIT_BITS'(9);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 7'h00;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]        radix;
        logic                         upper_case;
    } sira_in_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 last;
        logic                 bad_radix;
    } sira_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_SIGN,
        ST_EMIT
    } sira_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic emit_sign;
        logic emit_digit;
        logic emit_error;
    } sira_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radix_ok;
        logic div_last;
        logic quot_zero;
        logic is_negative;
        logic emit_last;
    } sira_sts_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                       input logic upper);
        logic [CHAR_BITS:0] sum;
        begin
            if (d > DIGIT_LIMIT)
            begin
                sum = {1'b0, (upper ? CHAR_UPPER : CHAR_LOWER)} + {2'b00, d} - (CHAR_BITS+1)'(10);
            end
            else
            begin
                sum = {1'b0, CHAR_ZERO} + {2'b00, d};
            end
            digit_char = sum[CHAR_BITS-1:0];
        end
    endfunction

endpackage

// File: hdl/sira_ctrl.sv
// Controller state machine of the radix ASCII unit.
`timescale 1ns / 1ps

module sira_ctrl
    import sira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sira_sts_t sts,
    output sira_cmd_t cmd,
    output logic      busy
);

    sira_state_t state_reg;
    sira_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (sts.radix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.emit_error = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store_digit = 1'b1;
                if (!sts.quot_zero)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (sts.is_negative)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (sts.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sira_datapath.sv
// Datapath of the radix ASCII unit: divider, digit store, counters and result register.
`timescale 1ns / 1ps

module sira_datapath
    import sira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sira_in_t  item,
    input  sira_cmd_t cmd,
    output sira_sts_t sts,
    output logic      strobe,
    output sira_out_t result
);

    localparam logic [BIT_CNT_BITS-1:0] BIT_LAST = BIT_CNT_BITS'(VALUE_BITS - 1);

    logic [DIGIT_BITS-1:0]   digit_store [VALUE_BITS];

    logic [VALUE_BITS-1:0]   mag_reg;
    logic [VALUE_BITS-1:0]   mag_next;
    logic [DIGIT_BITS-1:0]   rem_reg;
    logic [DIGIT_BITS-1:0]   rem_next;
    logic [BIT_CNT_BITS-1:0] bit_cnt_reg;
    logic [BIT_CNT_BITS-1:0] bit_cnt_next;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [CNT_BITS-1:0]     cnt_next;
    logic [RADIX_BITS-1:0]   radix_reg;
    logic                    neg_reg;
    logic                    upper_reg;
    logic                    strobe_reg;
    logic                    strobe_next;
    sira_out_t               result_reg;
    sira_out_t               result_next;

    logic [DIGIT_BITS:0]     trial;
    logic [DIGIT_BITS:0]     trial_sub;
    logic                    fits;
    logic [CNT_BITS-1:0]     rd_cnt;
    logic [DIGIT_BITS-1:0]   rd_digit;

    // One restoring division step: shift a dividend bit into the remainder.
    assign trial     = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign trial_sub = trial - {1'b0, radix_reg};
    assign fits      = (trial >= {1'b0, radix_reg});

    assign rd_cnt   = cnt_reg - CNT_BITS'(1);
    assign rd_digit = digit_store[rd_cnt[IDX_BITS-1:0]];

    assign sts.radix_ok    = (item.radix >= RADIX_MIN) && (item.radix <= RADIX_MAX);
    assign sts.div_last    = (bit_cnt_reg == BIT_LAST);
    assign sts.quot_zero   = (mag_reg == '0);
    assign sts.is_negative = neg_reg;
    assign sts.emit_last   = (cnt_reg == CNT_BITS'(1));

    always_comb
    begin
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        if (cmd.load)
        begin
            mag_next     = item.value[VALUE_BITS-1] ? (~item.value + 1'b1) : item.value;
            rem_next     = '0;
            bit_cnt_next = '0;
            cnt_next     = '0;
        end
        if (cmd.div_step)
        begin
            mag_next     = {mag_reg[VALUE_BITS-2:0], fits};
            rem_next     = fits ? trial_sub[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
            bit_cnt_next = bit_cnt_reg + BIT_CNT_BITS'(1);
        end
        if (cmd.store_digit)
        begin
            rem_next     = '0;
            bit_cnt_next = '0;
            cnt_next     = cnt_reg + CNT_BITS'(1);
        end
        if (cmd.emit_error)
        begin
            strobe_next           = 1'b1;
            result_next.char_code = CHAR_NUL;
            result_next.last      = 1'b1;
            result_next.bad_radix = 1'b1;
        end
        if (cmd.emit_sign)
        begin
            strobe_next           = 1'b1;
            result_next.char_code = CHAR_MINUS;
            result_next.last      = 1'b0;
            result_next.bad_radix = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            strobe_next           = 1'b1;
            result_next.char_code = digit_char(rd_digit, upper_reg);
            result_next.last      = sts.emit_last;
            result_next.bad_radix = 1'b0;
            cnt_next              = rd_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg     <= '0;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            mag_reg     <= mag_next;
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
            strobe_reg  <= strobe_next;
            if (cmd.load)
            begin
                neg_reg <= item.value[VALUE_BITS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        result_reg <= result_next;
        if (cmd.load)
        begin
            radix_reg <= item.radix;
            upper_reg <= item.upper_case;
        end
        if (cmd.store_digit)
        begin
            digit_store[cnt_reg[IDX_BITS-1:0]] <= rem_reg;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// File: hdl/signed_int_to_radix_ascii_unit.sv
// Top level of the signed integer to radix ASCII unit: controller plus datapath.
// Each digit comes from the one-bit-per-cycle restoring divider (VALUE_BITS steps per digit);
//   the sign and digits then go out at one emitted character per cycle, and the next number
//   is taken only in the idle state after the last character.
// A bad radix gives its single error result in the cycle after start; busy stays low.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops the strobe;
//   results are shown for one cycle each and the receiver cannot stall them.
`timescale 1ns / 1ps

module signed_int_to_radix_ascii_unit
    import sira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  sira_in_t  item,
    output logic      strobe,
    output sira_out_t result
);

    // Control and status between the sequencer and the datapath.
    sira_cmd_t cmd;
    sira_sts_t sts;

    // Sequencer: accept a transaction or flag a bad radix, run one division per digit, then emit
    // the sign of a negative value and the stored digits in reverse order.
    sira_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: hold the magnitude, divide it, store remainders, and drive
    // the registered result of each transaction.
    sira_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .strobe (strobe),
        .result (result)
    );

endmodule

// File: hdl/sira_checker.sv
// Port-level checker for the radix ASCII unit, with its bind to the top level.
`timescale 1ns / 1ps

module sira_checker
    import sira_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input sira_in_t  item,
    input logic      strobe,
    input sira_out_t result
);

    logic bad_in;

    assign bad_in = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);

    // An error result is a lone NUL marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.bad_radix |-> result.last && (result.char_code == CHAR_NUL))
        else $error("error result malformed");

    // A bad radix answers next cycle with the error result.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && bad_in |=> strobe && result.bad_radix && !busy)
        else $error("bad radix not reported");

    // A good radix starts a conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !bad_in |=> busy && !strobe)
        else $error("conversion did not start");

    // More characters are pending while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("non-last character while idle");

    // Going idle coincides with the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last && !result.bad_radix)
        else $error("idle without final character");

endmodule

bind signed_int_to_radix_ascii_unit sira_checker u_sira_checker (.*);
